// ===== sv/iso_ring_feedback_control_assert.svh =====
// Assertion helpers used by the back end (irfc_back) of the ring feedback block.
// Both expect a clock named clk and an active-low reset named rst_n.
`ifndef ISO_RING_FEEDBACK_CONTROL_ASSERT_SVH
`define ISO_RING_FEEDBACK_CONTROL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRFC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IRFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/irfc_pkg.sv =====
package irfc_pkg;

    localparam int RING_BYTES = 16384;
    localparam int MAX_PACKET = 1024;

    localparam int LEN_W  = $clog2(RING_BYTES + 1);
    localparam int OFF_W  = $clog2(RING_BYTES);
    localparam int DIST_W = LEN_W + 1;

    localparam logic [3:0] RATE_TOP = 4'd9;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Input commands.
    localparam logic [1:0] CMD_STOP   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_PACKET = 2'd2;
    localparam logic [1:0] CMD_DONE   = 2'd3;

    // Work codes passed from the front to the back.
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_PACKET = 2'd2;
    localparam logic [1:0] OP_DONE   = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_XFER     = 2'd1;
    localparam logic [1:0] KIND_FEEDBACK = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RATE    = 2'd0;
    localparam logic [1:0] CFG_NOMINAL = 2'd1;
    localparam logic [1:0] CFG_LOW     = 2'd2;
    localparam logic [1:0] CFG_HIGH    = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic        half_length;
        logic [10:0] byte_count;
        logic [13:0] read_position;
        logic        feedback_busy;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [13:0] transfer_offset;
        logic [10:0] transfer_length;
        logic [31:0] feedback_word;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  sample_rate_index;
        logic [31:0] feedback_nominal;
        logic [31:0] feedback_low;
        logic [31:0] feedback_high;
    } cfg_regs_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [LEN_W-1:0] ring_len;
        logic [10:0]      count;
        logic [13:0]      read_position;
        logic             feedback_busy;
    } work_t;

endpackage

// ===== sv/iso_ring_feedback_control.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_data (command, packet and reader fields)
// out       output     out_valid / out_stall out_data (transfer or feedback word)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request per cycle is accepted while in_stall is low; its result passes
// through the two-entry queue and then the output register.
// Reset clears the ring state and configuration (rate index resets to 1).
// A stalled output holds the back end; requests keep entering until the
// queue holds two, then in_stall rises. cfg_ready is always high.
module iso_ring_feedback_control (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  irfc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output irfc_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import irfc_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;
    work_t     front_work;
    work_t     q_head;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_not_empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RATE:    cfg_next.sample_rate_index = cfg_data[3:0];
                CFG_NOMINAL: cfg_next.feedback_nominal  = cfg_data;
                CFG_LOW:     cfg_next.feedback_low      = cfg_data;
                CFG_HIGH:    cfg_next.feedback_high     = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{4'd1, 32'd0, 32'd0, 32'd0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    irfc_front u_front (
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .in_data           (in_data),
        .sample_rate_index (cfg_reg.sample_rate_index),
        .q_full            (q_full),
        .push              (q_push),
        .work              (front_work)
    );

    irfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_work),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    irfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .head      (q_head),
        .pop       (q_pop),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== sv/irfc_front.sv =====
module irfc_front (
    input  logic               in_valid,
    output logic               in_stall,
    input  irfc_pkg::in_item_t in_data,
    input  logic [3:0]         sample_rate_index,
    input  logic               q_full,
    output logic               push,
    output irfc_pkg::work_t    work
);
    import irfc_pkg::*;

    logic [3:0]       rate_idx;
    logic [3:0]       shift_amt;
    logic [LEN_W-1:0] full_len;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // The ring size only depends on configuration and the start request,
    // so it is worked out here, before the request enters the queue.
    always_comb
    begin
        rate_idx  = (sample_rate_index > RATE_TOP) ? RATE_TOP : sample_rate_index;
        shift_amt = (RATE_TOP - rate_idx) >> 1;
        full_len  = LEN_W'(RING_BYTES) >> shift_amt;

        work.ring_len      = in_data.half_length ? (full_len >> 1) : full_len;
        work.read_position = in_data.read_position;
        work.feedback_busy = in_data.feedback_busy;

        if ({1'b0, in_data.byte_count} > 12'(MAX_PACKET))
        begin
            work.count = 11'(MAX_PACKET);
        end
        else
        begin
            work.count = in_data.byte_count;
        end

        case (in_data.command)
            CMD_START:  work.op = OP_START;
            CMD_PACKET: work.op = OP_PACKET;
            CMD_DONE:   work.op = OP_DONE;
            default:    work.op = OP_NONE;
        endcase
    end

endmodule

// ===== sv/irfc_queue.sv =====
module irfc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  irfc_pkg::work_t push_data,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output irfc_pkg::work_t head
);
    import irfc_pkg::*;

    work_t             entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/irfc_back.sv =====
`include "iso_ring_feedback_control_assert.svh"

module irfc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  irfc_pkg::work_t     head,
    output logic                pop,
    input  irfc_pkg::cfg_regs_t cfg,
    output logic                out_valid,
    input  logic                out_stall,
    output irfc_pkg::out_item_t out_data
);
    import irfc_pkg::*;

    logic [OFF_W-1:0]  wr_off_reg;
    logic [OFF_W-1:0]  wr_off_next;
    logic [10:0]       rem_reg;
    logic [10:0]       rem_next;
    logic [LEN_W-1:0]  ring_len_reg;
    logic [LEN_W-1:0]  ring_len_next;
    logic              out_valid_reg;
    out_item_t         out_data_reg;
    out_item_t         result;

    logic [LEN_W-1:0]  lim_count;
    logic [LEN_W:0]    pos_sum;
    logic [LEN_W:0]    wrap_rest;
    logic [DIST_W-1:0] rpos_ext;
    logic [DIST_W-1:0] off_ext;
    logic [DIST_W-1:0] gap;
    logic [DIST_W-1:0] low_mark;
    logic [DIST_W-1:0] high_mark;

    assign pop       = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        ring_len_next = ring_len_reg;
        wr_off_next   = wr_off_reg;
        rem_next      = rem_reg;
        result        = '0;

        // A packet never moves more than the ring holds.
        lim_count = (LEN_W'(head.count) > ring_len_reg) ? ring_len_reg : LEN_W'(head.count);
        pos_sum   = (LEN_W + 1)'(wr_off_reg) + (LEN_W + 1)'(lim_count);
        wrap_rest = pos_sum - {1'b0, ring_len_reg};

        // Distance from the write offset forward to the reader, taken around the ring.
        rpos_ext  = DIST_W'(head.read_position);
        off_ext   = DIST_W'(wr_off_reg);
        if (rpos_ext >= off_ext)
        begin
            gap = rpos_ext - off_ext;
        end
        else
        begin
            gap = rpos_ext + DIST_W'(ring_len_reg) - off_ext;
        end
        low_mark  = DIST_W'(ring_len_reg >> 4);
        high_mark = DIST_W'(ring_len_reg >> 3);

        case (head.op)
            OP_START:
            begin
                ring_len_next        = head.ring_len;
                wr_off_next          = OFF_W'(head.ring_len >> 1);
                rem_next             = '0;
                result.result_kind   = KIND_FEEDBACK;
                result.feedback_word = cfg.feedback_nominal;
            end
            OP_PACKET:
            begin
                if (ring_len_reg != '0)
                begin
                    result.result_kind     = KIND_XFER;
                    result.transfer_offset = 14'(wr_off_reg);
                    if (pos_sum >= {1'b0, ring_len_reg})
                    begin
                        rem_next               = 11'(wrap_rest);
                        wr_off_next            = OFF_W'(wrap_rest);
                        result.transfer_length = 11'(lim_count - wrap_rest[LEN_W-1:0]);
                    end
                    else
                    begin
                        wr_off_next            = OFF_W'(pos_sum);
                        result.transfer_length = 11'(lim_count);
                    end
                end
            end
            OP_DONE:
            begin
                if (rem_reg != '0)
                begin
                    result.result_kind     = KIND_XFER;
                    result.transfer_length = rem_reg;
                    rem_next               = '0;
                end
                else if (!head.feedback_busy)
                begin
                    result.result_kind = KIND_FEEDBACK;
                    if (gap < low_mark)
                    begin
                        result.feedback_word = cfg.feedback_low;
                    end
                    else if (gap > high_mark)
                    begin
                        result.feedback_word = cfg.feedback_high;
                    end
                    else
                    begin
                        result.feedback_word = cfg.feedback_nominal;
                    end
                end
            end
            default:
            begin
                result.result_kind = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_off_reg    <= '0;
            rem_reg       <= '0;
            ring_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                wr_off_reg    <= wr_off_next;
                rem_reg       <= rem_next;
                ring_len_reg  <= ring_len_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= result;
        end
    end

    `IRFC_ASSERT_SAME(a_offset_in_ring, ring_len_reg != '0, wr_off_reg < ring_len_reg, "write offset left the ring")
    `IRFC_ASSERT_NEXT(a_rem_cleared, pop && head.op == OP_DONE && rem_reg != '0, rem_reg == '0, "remainder not cleared after issue")
    `IRFC_ASSERT_SAME(a_no_pop_blocked, out_valid_reg && out_stall, !pop, "request taken while result is held")

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import irfc_pkg::*;

    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 140;
    localparam int DIR_ROWS       = 26;
    localparam int DIR_RESET_ROWS = 4;

    localparam logic [31:0] DIR_NOM  = 32'h0001_0000;
    localparam logic [31:0] DIR_LOW  = 32'h0000_F000;
    localparam logic [31:0] DIR_HIGH = 32'h0001_1000;

    localparam out_item_t NO_RESULT = '{KIND_NONE, 14'd0, 11'd0, 32'd0};
    localparam out_item_t FB_ZERO   = '{KIND_FEEDBACK, 14'd0, 11'd0, 32'd0};
    localparam out_item_t FB_NOM    = '{KIND_FEEDBACK, 14'd0, 11'd0, DIR_NOM};

    localparam logic [3:0] RATE_PLAN [PHASES] =
        '{4'd0, 4'd9, 4'd15, 4'd4, 4'd12, 4'd7, 4'd1, 4'd2};

    typedef struct packed {
        in_item_t  req;
        logic      typed;
        out_item_t want;
    } plan_row_t;

    // Rows with typed set carry a result that is obvious from the request;
    // the others are checked against the ring predictor.
    plan_row_t dir_plan [DIR_ROWS] = '{
        // Reset settings: ring not sized yet.
        '{'{CMD_PACKET, 1'b0, 11'd100,  14'd0,     1'b0}, 1'b1, NO_RESULT},
        '{'{CMD_DONE,   1'b0, 11'd0,    14'd5,     1'b1}, 1'b1, NO_RESULT},
        '{'{CMD_STOP,   1'b0, 11'd0,    14'd0,     1'b0}, 1'b1, NO_RESULT},
        '{'{CMD_START,  1'b0, 11'd0,    14'd0,     1'b0}, 1'b1, FB_ZERO},
        // Rate index 0: ring of 1024 bytes, marks at 64 and 128.
        '{'{CMD_START,  1'b0, 11'd0,    14'd0,     1'b0}, 1'b1, FB_NOM},
        '{'{CMD_PACKET, 1'b0, 11'd2047, 14'd0,     1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_DONE,   1'b0, 11'd0,    14'd0,     1'b1}, 1'b0, NO_RESULT},
        '{'{CMD_PACKET, 1'b0, 11'd512,  14'd0,     1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_DONE,   1'b0, 11'd0,    14'd0,     1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_DONE,   1'b0, 11'd0,    14'd63,    1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_DONE,   1'b0, 11'd0,    14'd64,    1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_DONE,   1'b0, 11'd0,    14'd128,   1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_DONE,   1'b0, 11'd0,    14'd129,   1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_DONE,   1'b0, 11'd0,    14'd16383, 1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_DONE,   1'b1, 11'd2047, 14'd16383, 1'b1}, 1'b1, NO_RESULT},
        '{'{CMD_PACKET, 1'b1, 11'd0,    14'd16383, 1'b1}, 1'b0, NO_RESULT},
        '{'{CMD_PACKET, 1'b0, 11'd100,  14'd0,     1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_DONE,   1'b0, 11'd0,    14'd50,    1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_PACKET, 1'b0, 11'd1000, 14'd0,     1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_PACKET, 1'b0, 11'd1000, 14'd0,     1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_PACKET, 1'b0, 11'd10,   14'd0,     1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_DONE,   1'b0, 11'd0,    14'd0,     1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_STOP,   1'b1, 11'd2047, 14'd16383, 1'b1}, 1'b1, NO_RESULT},
        '{'{CMD_PACKET, 1'b0, 11'd1024, 14'd0,     1'b0}, 1'b0, NO_RESULT},
        '{'{CMD_START,  1'b1, 11'd0,    14'd0,     1'b0}, 1'b1, FB_NOM},
        '{'{CMD_PACKET, 1'b0, 11'd2047, 14'd0,     1'b0}, 1'b0, NO_RESULT}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // Expectation attached to the request on the input channel.
    logic        req_typed;
    out_item_t   req_want;

    // Predictor state and its copy of the settings.
    logic [13:0] wr_ofs;
    logic [10:0] wrap_rest;
    logic [14:0] ring_len;
    logic [3:0]  m_rate;
    logic [31:0] m_nom;
    logic [31:0] m_low;
    logic [31:0] m_high;

    out_item_t   pending_results [$];
    out_item_t   predicted;
    out_item_t   got_item;
    out_item_t   want_item;

    int          n_requests;
    int          n_cfg_writes;
    int          n_xfers;
    int          n_feedback;
    int          n_none;
    int          n_errors;
    int          quiet_cycles;
    int          send_idle_pct;
    int          stall_pct;

    iso_ring_feedback_control i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Works out the one result of a request and advances the ring state.
    function automatic out_item_t next_ring_result(in_item_t req);
        out_item_t   r;
        int unsigned idx;
        int unsigned cnt;
        int unsigned nxt;
        int unsigned rp;
        int unsigned gap;
        r = '0;
        case (req.command)
            CMD_START:
            begin
                idx = (m_rate > RATE_TOP) ? RATE_TOP : m_rate;
                ring_len = 15'(RING_BYTES >> ((RATE_TOP - idx) >> 1));
                if (req.half_length)
                    ring_len = ring_len >> 1;
                wr_ofs = 14'(ring_len >> 1);
                wrap_rest = '0;
                r.result_kind = KIND_FEEDBACK;
                r.feedback_word = m_nom;
            end
            CMD_PACKET:
            begin
                if (ring_len != 0)
                begin
                    cnt = req.byte_count;
                    if (cnt > MAX_PACKET)
                        cnt = MAX_PACKET;
                    if (cnt > ring_len)
                        cnt = ring_len;
                    nxt = wr_ofs + cnt;
                    r.result_kind = KIND_XFER;
                    r.transfer_offset = wr_ofs;
                    if (nxt >= ring_len)
                    begin
                        // The part past the ring end waits for the next done event.
                        wrap_rest = 11'(nxt - ring_len);
                        wr_ofs = 14'(nxt - ring_len);
                        cnt = cnt - (nxt - ring_len);
                    end
                    else
                        wr_ofs = 14'(nxt);
                    r.transfer_length = 11'(cnt);
                end
            end
            CMD_DONE:
            begin
                if (wrap_rest != 0)
                begin
                    r.result_kind = KIND_XFER;
                    r.transfer_length = wrap_rest;
                    wrap_rest = '0;
                end
                else if (!req.feedback_busy)
                begin
                    rp = req.read_position;
                    if (rp >= wr_ofs)
                        gap = rp - wr_ofs;
                    else
                        gap = rp + ring_len - wr_ofs;
                    r.result_kind = KIND_FEEDBACK;
                    if (gap < (ring_len >> 4))
                        r.feedback_word = m_low;
                    else if (gap > (ring_len >> 3))
                        r.feedback_word = m_high;
                    else
                        r.feedback_word = m_nom;
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // Mostly packets and done events around the live write offset, so that
    // wraps and the feedback marks come up often; starts and stops are rare.
    function automatic in_item_t random_request();
        in_item_t    r;
        int unsigned pick;
        int unsigned room;
        int unsigned aim;
        r.half_length = 1'($urandom_range(1));
        r.byte_count = 11'($urandom_range(2047));
        r.read_position = 14'($urandom_range(16383));
        r.feedback_busy = ($urandom_range(99) < 25);
        pick = $urandom_range(99);
        if (ring_len == 0 || pick < 5)
            r.command = CMD_START;
        else if (pick < 9)
            r.command = CMD_STOP;
        else if (pick < 55)
        begin
            r.command = CMD_PACKET;
            room = ring_len - wr_ofs;
            case ($urandom_range(9))
                0: r.byte_count = (room > 2047) ? 11'd2047 : 11'(room);
                1: r.byte_count = 11'($urandom_range(2047));
                default: r.byte_count = 11'($urandom_range(MAX_PACKET));
            endcase
        end
        else
        begin
            r.command = CMD_DONE;
            pick = $urandom_range(9);
            if (pick < 6)
            begin
                aim = wr_ofs + $urandom_range(ring_len >> 2);
                r.read_position = 14'(aim % ring_len);
            end
            else if (pick < 8)
            begin
                aim = wr_ofs + (ring_len >> (3 + $urandom_range(1))) + $urandom_range(2) - 1;
                r.read_position = 14'(aim % ring_len);
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted = next_ring_result(in_data);
                pending_results.push_back(req_typed ? req_want : predicted);
                n_requests++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RATE:    m_rate = cfg_data[3:0];
                    CFG_NOMINAL: m_nom = cfg_data;
                    CFG_LOW:     m_low = cfg_data;
                    CFG_HIGH:    m_high = cfg_data;
                    default:     m_rate = m_rate;
                endcase
                n_cfg_writes++;
            end
            if (out_valid && !out_stall)
            begin
                got_item = out_data;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with no request pending, kind %0d",
                             $time, got_item.result_kind);
                    n_errors++;
                end
                else
                begin
                    want_item = pending_results.pop_front();
                    check_field("result_kind", 32'(want_item.result_kind),
                                32'(got_item.result_kind));
                    check_field("transfer_offset", 32'(want_item.transfer_offset),
                                32'(got_item.transfer_offset));
                    check_field("transfer_length", 32'(want_item.transfer_length),
                                32'(got_item.transfer_length));
                    check_field("feedback_word", want_item.feedback_word,
                                got_item.feedback_word);
                    case (want_item.result_kind)
                        KIND_XFER:     n_xfers++;
                        KIND_FEEDBACK: n_feedback++;
                        default:       n_none++;
                    endcase
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: watchdog, no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a back-to-back request lowers it only for idling that send_idle_pct asks for.
    task automatic push_request(in_item_t req, logic typed, out_item_t want);
        int target;
        target = n_requests + 1;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        req_typed <= typed;
        req_want <= want;
        @(negedge clk);
        while (n_requests < target)
            @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        int target;
        target = n_cfg_writes + 1;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        while (n_cfg_writes < target)
            @(negedge clk);
    endtask

    task automatic apply_settings(logic [3:0] rate, logic [31:0] nom, logic [31:0] low,
                                  logic [31:0] high);
        wait_idle();
        write_reg(CFG_RATE, {28'd0, rate});
        write_reg(CFG_NOMINAL, nom);
        write_reg(CFG_LOW, low);
        write_reg(CFG_HIGH, high);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int          ph;
        int          k;
        logic [31:0] w_nom;
        logic [31:0] w_low;
        logic [31:0] w_high;
        in_item_t    opener;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        req_typed = 1'b0;
        req_want = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RATE;
        cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        n_requests = 0;
        n_cfg_writes = 0;
        n_xfers = 0;
        n_feedback = 0;
        n_none = 0;
        n_errors = 0;
        quiet_cycles = 0;
        wr_ofs = '0;
        wrap_rest = '0;
        ring_len = '0;
        m_rate = 4'd1;
        m_nom = '0;
        m_low = '0;
        m_high = '0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (k == DIR_RESET_ROWS)
                apply_settings(4'd0, DIR_NOM, DIR_LOW, DIR_HIGH);
            push_request(dir_plan[k].req, dir_plan[k].typed, dir_plan[k].want);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            w_nom = $urandom;
            w_low = $urandom;
            w_high = $urandom;
            if (ph == 2)
            begin
                w_low = 32'h0000_0000;
                w_nom = 32'h8000_0000;
                w_high = 32'hFFFF_FFFF;
            end
            else if (ph == 5)
            begin
                w_low = 32'hFFFF_FFFF;
                w_nom = 32'h0000_0000;
                w_high = 32'h0000_0001;
            end
            apply_settings(RATE_PLAN[ph], w_nom, w_low, w_high);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            // A new rate only takes effect on a start, so each phase opens with one.
            opener = random_request();
            opener.command = CMD_START;
            push_request(opener, 1'b0, NO_RESULT);
            for (k = 1; k < PHASE_REQUESTS; k++)
                push_request(random_request(), 1'b0, NO_RESULT);
        end

        wait_idle();
        $display("Ran %0d requests through %0d rate and feedback settings, with and without idling.",
                 n_requests, PHASES + 2);
        $display("Checked %0d transfers, %0d feedback words and %0d empty results.",
                 n_xfers, n_feedback, n_none);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
